FILE: rtl/gaussian_blur_5x5_rgb_macros.svh
// assertion macros shared by the gaussian blur rtl
// expects clk and arst_n in the scope of the module that uses them
`ifndef GAUSSIAN_BLUR_5X5_RGB_MACROS_SVH
`define GAUSSIAN_BLUR_5X5_RGB_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, off during reset
`define GB_ASSERT_IMPLY(name, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("gaussian blur check failed");

// next-cycle implication, sampled on clk, off during reset
`define GB_ASSERT_NEXT(name, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("gaussian blur check failed");

`else

`define GB_ASSERT_IMPLY(name, cond, prop)
`define GB_ASSERT_NEXT(name, cond, prop)

`endif

`endif

FILE: rtl/gblur_pkg.sv
// types, constants and kernel arithmetic for the 5x5 gaussian blur
// no dependencies
`timescale 1ns / 1ps

package gblur_pkg;

	localparam int MAX_WIDTH   = 4096;
	localparam int KERNEL_SIZE = 5;
	localparam int LINES       = KERNEL_SIZE - 1;
	localparam int HALF        = KERNEL_SIZE / 2;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int EW_W   = COL_W + 1;
	localparam int SLOT_W = $clog2(LINES);
	localparam int ROW_W  = 16;
	localparam int FW_W   = 13;
	localparam int FH_W   = 16;
	localparam int CH_W   = 8;
	localparam int VS_W   = 12;
	localparam int HS_W   = 16;
	localparam int OUT_COL_W = 12;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [FW_W-1:0] MIN_WIDTH  = 13'd5;
	localparam logic [FH_W-1:0] MIN_HEIGHT = 16'd5;
	localparam logic [FW_W-1:0] RST_WIDTH  = 13'd4000;
	localparam logic [FH_W-1:0] RST_HEIGHT = 16'd4000;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} pix_t;

	typedef struct packed {
		logic [VS_W-1:0] blue;
		logic [VS_W-1:0] green;
		logic [VS_W-1:0] red;
	} vsum_t;

	// line store access for one accepted pixel
	typedef struct packed {
		logic              en;
		logic [COL_W-1:0]  addr;
		logic [SLOT_W-1:0] slot;
	} lb_ctl_t;

	// 1 4 6 4 1 weighting of five samples
	function automatic logic [HS_W-1:0] binom5(input logic [HS_W-1:0] a, input logic [HS_W-1:0] b,
		input logic [HS_W-1:0] c, input logic [HS_W-1:0] d, input logic [HS_W-1:0] e);
		binom5 = a + (b << 2) + (c << 2) + (c << 1) + (d << 2) + e;
	endfunction

endpackage

FILE: rtl/gaussian_blur_5x5_rgb.sv
// top level of the streaming 5x5 rgb gaussian blur
// depends on gblur_pkg, gblur_linebuf, gblur_window and the assertion macro header
`timescale 1ns / 1ps

// Streaming 5x5 binomial blur of an RGB raster image, one 24-bit pixel word
// per clock with no gaps. Each pixel word accepted on the input is written to
// one of four line stores (one block RAM per line, MAX_WIDTH words deep, read
// and written at the same column in the same cycle), and the four older rows
// of that column come back registered. A column of 5 pixels is weighted
// vertically with 1 4 6 4 1 and pushed into a five-deep register window, which
// is weighted horizontally the same way and cut to the top byte. Only interior
// pixels come out: the result for (r-2, c-2) leaves with input (r, c) once
// r >= 4 and c >= 4, tagged with its row, column and a last-of-frame flag.
// Sustained rate is one pixel per clock, set by the single-port line stores
// and the register window; a word passes stage 1, stage 2 and the output
// register. The pipeline stalls only when the output is held and every
// stage is full. frame_width (5..MAX_WIDTH, clamped) and frame_height (5 and
// up) reset to 4000 and should be written only while no pixel is in flight;
// the line stores are not cleared after reset.

`include "gaussian_blur_5x5_rgb_macros.svh"

module gaussian_blur_5x5_rgb (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [gblur_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gblur_pkg::CFG_DATA_W-1:0]     cfg_data,
	// pixel input
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [gblur_pkg::CH_W-1:0]           red_in,
	input  logic [gblur_pkg::CH_W-1:0]           green_in,
	input  logic [gblur_pkg::CH_W-1:0]           blue_in,
	// blurred output
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [gblur_pkg::CH_W-1:0]           red_out,
	output logic [gblur_pkg::CH_W-1:0]           green_out,
	output logic [gblur_pkg::CH_W-1:0]           blue_out,
	output logic [gblur_pkg::ROW_W-1:0]          out_row,
	output logic [gblur_pkg::OUT_COL_W-1:0]      out_col,
	output logic                                 last_of_frame
);

	// configuration registers
	logic [gblur_pkg::FW_W-1:0] frame_width_q;
	logic [gblur_pkg::FH_W-1:0] frame_height_q;

	// raster position of the next word
	logic [gblur_pkg::ROW_W-1:0] row_q;
	logic [gblur_pkg::COL_W-1:0] col_q;

	// clamped frame size
	logic [gblur_pkg::EW_W-1:0]  eff_w;
	logic [gblur_pkg::FH_W-1:0]  eff_h;

	// position of the word being accepted
	logic                        wrap_col;
	logic [gblur_pkg::ROW_W:0]   row_pre;
	logic [gblur_pkg::ROW_W-1:0] r_cur;
	logic [gblur_pkg::COL_W-1:0] c_cur;
	logic [gblur_pkg::EW_W-1:0]  c_next;
	logic [gblur_pkg::ROW_W:0]   r_next;
	logic                        end_row;
	logic                        end_frame;
	logic                        emit;
	logic                        is_last;

	// handshake
	logic accept;
	logic out_free;
	logic s1_free;
	logic s2_free;
	logic s1_move;

	// stage 1: line store read data arrives alongside these
	logic                         valid_s1;
	logic                         emit_s1;
	logic                         last_s1;
	logic [gblur_pkg::ROW_W-1:0]  row_s1;
	logic [gblur_pkg::OUT_COL_W-1:0] col_s1;
	logic [gblur_pkg::SLOT_W-1:0] slot_s1;
	gblur_pkg::pix_t              px_s1;

	// stage 2: window holds the five column sums of this word
	logic                         valid_s2;
	logic                         emit_s2;
	logic                         last_s2;
	logic [gblur_pkg::ROW_W-1:0]  row_s2;
	logic [gblur_pkg::OUT_COL_W-1:0] col_s2;

	// output register
	logic out_valid_q;

	gblur_pkg::lb_ctl_t lb_ctl;
	gblur_pkg::pix_t    px_in;
	gblur_pkg::pix_t    lb_rdata [gblur_pkg::LINES];
	gblur_pkg::pix_t    column [gblur_pkg::KERNEL_SIZE];
	gblur_pkg::pix_t    blur;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= gblur_pkg::RST_WIDTH;
			frame_height_q <= gblur_pkg::RST_HEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gblur_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[gblur_pkg::FW_W-1:0];
				gblur_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data[gblur_pkg::FH_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp width and height to at least 5, and width to what the line stores hold
	always_comb begin
		if (frame_width_q < gblur_pkg::MIN_WIDTH) begin
			eff_w = gblur_pkg::EW_W'(gblur_pkg::MIN_WIDTH);
		end else if (frame_width_q > gblur_pkg::FW_W'(gblur_pkg::MAX_WIDTH)) begin
			eff_w = gblur_pkg::EW_W'(gblur_pkg::MAX_WIDTH);
		end else begin
			eff_w = gblur_pkg::EW_W'(frame_width_q);
		end
		if (frame_height_q < gblur_pkg::MIN_HEIGHT) begin
			eff_h = gblur_pkg::MIN_HEIGHT;
		end else begin
			eff_h = frame_height_q;
		end
	end

	// position of this word; a shrunk size ends the row or frame at once
	always_comb begin
		wrap_col = {1'b0, col_q} >= eff_w;
		row_pre  = wrap_col ? ({1'b0, row_q} + 1'b1) : {1'b0, row_q};
		r_cur    = (row_pre >= {1'b0, eff_h}) ? '0 : row_pre[gblur_pkg::ROW_W-1:0];
		c_cur    = wrap_col ? '0 : col_q;
		c_next   = {1'b0, c_cur} + 1'b1;
		r_next   = {1'b0, r_cur} + 1'b1;
		end_row  = c_next >= eff_w;
		end_frame = r_next >= {1'b0, eff_h};
		emit     = (r_cur >= gblur_pkg::ROW_W'(gblur_pkg::LINES))
			&& (c_cur >= gblur_pkg::COL_W'(gblur_pkg::LINES));
		is_last  = (r_cur == eff_h - 1'b1) && ({1'b0, c_cur} == eff_w - 1'b1);
	end

	// ready chain from the output back to the input
	assign out_free = !out_valid_q || !out_stall;
	assign s2_free  = !valid_s2 || !emit_s2 || out_free;
	assign s1_free  = !valid_s1 || s2_free;
	assign s1_move  = valid_s1 && s2_free;
	assign in_stall = !s1_free;
	assign accept   = in_valid && s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (end_row) begin
				col_q <= '0;
				row_q <= end_frame ? '0 : r_next[gblur_pkg::ROW_W-1:0];
			end else begin
				col_q <= c_next[gblur_pkg::COL_W-1:0];
				row_q <= r_cur;
			end
		end
	end

	// line stores: rows r-4 .. r-1 come back, row r replaces the oldest
	always_comb begin
		px_in.red    = red_in;
		px_in.green  = green_in;
		px_in.blue   = blue_in;
		lb_ctl.en    = accept;
		lb_ctl.addr  = c_cur;
		lb_ctl.slot  = r_cur[gblur_pkg::SLOT_W-1:0];
	end

	gblur_linebuf u_linebuf (
		.clk   (clk),
		.ctl   (lb_ctl),
		.wdata (px_in),
		.rdata (lb_rdata)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= accept;
		end
	end

	// stage 1 payload, loaded together with the line store read
	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1 <= emit;
			last_s1 <= is_last;
			row_s1  <= r_cur - gblur_pkg::ROW_W'(gblur_pkg::HALF);
			col_s1  <= gblur_pkg::OUT_COL_W'(c_cur - gblur_pkg::COL_W'(gblur_pkg::HALF));
			slot_s1 <= r_cur[gblur_pkg::SLOT_W-1:0];
			px_s1   <= px_in;
		end
	end

	// reorder the line stores oldest row first; slot of row r held row r-4
	always_comb begin
		for (int i = 0; i < gblur_pkg::LINES; i++) begin
			column[i] = lb_rdata[slot_s1 + gblur_pkg::SLOT_W'(i)];
		end
		column[gblur_pkg::LINES] = px_s1;
	end

	gblur_window u_window (
		.clk   (clk),
		.shift (s1_move),
		.col   (column),
		.blur  (blur)
	);

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_move;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			emit_s2 <= emit_s1;
			last_s2 <= last_s1;
			row_s2  <= row_s1;
			col_s2  <= col_s1;
		end
	end

	// output register, only interior pixels reach it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2 && emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2 && emit_s2) begin
			red_out       <= blur.red;
			green_out     <= blur.green;
			blue_out      <= blur.blue;
			out_row       <= row_s2;
			out_col       <= col_s2;
			last_of_frame <= last_s2;
		end
	end

	assign out_valid = out_valid_q;

	// an empty first stage always takes a word
	`GB_ASSERT_IMPLY(a_take_when_empty, !valid_s1, !in_stall)
	// a full pipeline behind a held output must stall the input
	`GB_ASSERT_IMPLY(a_full_stalls,
		valid_s1 && valid_s2 && emit_s2 && out_valid_q && out_stall, in_stall)
	// results are interior pixels only
	`GB_ASSERT_IMPLY(a_interior_only, out_valid_q,
		out_row >= gblur_pkg::ROW_W'(gblur_pkg::HALF)
		&& out_col >= gblur_pkg::OUT_COL_W'(gblur_pkg::HALF))
	// after a word the column counter sits inside the row it was given
	`GB_ASSERT_NEXT(a_col_in_row, accept, {1'b0, col_q} < $past(eff_w))

endmodule

FILE: rtl/gblur_linebuf.sv
// four line stores of one row each, read before write at the same column
// depends on gblur_pkg
`timescale 1ns / 1ps

module gblur_linebuf (
	input  logic               clk,
	input  gblur_pkg::lb_ctl_t ctl,
	input  gblur_pkg::pix_t    wdata,
	output gblur_pkg::pix_t    rdata [gblur_pkg::LINES]
);

	for (genvar i = 0; i < gblur_pkg::LINES; i++) begin : g_line
		gblur_pkg::pix_t mem [gblur_pkg::MAX_WIDTH];

		// registered read returns the old word when this line is the one written
		always_ff @(posedge clk) begin
			if (ctl.en) begin
				rdata[i] <= mem[ctl.addr];
				if (ctl.slot == gblur_pkg::SLOT_W'(i)) begin
					mem[ctl.addr] <= wdata;
				end
			end
		end
	end

endmodule

FILE: rtl/gblur_window.sv
// separable 5x5 window: vertical column sums shifted through five registers,
// horizontal weighting and divide by 256; depends on gblur_pkg
`timescale 1ns / 1ps

module gblur_window (
	input  logic            clk,
	input  logic            shift,
	input  gblur_pkg::pix_t col [gblur_pkg::KERNEL_SIZE],
	output gblur_pkg::pix_t blur
);

	gblur_pkg::vsum_t vs_new;
	gblur_pkg::vsum_t hwin_q [gblur_pkg::KERNEL_SIZE];
	logic [gblur_pkg::HS_W-1:0] hs_red, hs_green, hs_blue;

	// vertical 1 4 6 4 1 sum of the incoming column
	always_comb begin
		vs_new.red   = gblur_pkg::VS_W'(gblur_pkg::binom5(
			gblur_pkg::HS_W'(col[0].red), gblur_pkg::HS_W'(col[1].red),
			gblur_pkg::HS_W'(col[2].red), gblur_pkg::HS_W'(col[3].red),
			gblur_pkg::HS_W'(col[4].red)));
		vs_new.green = gblur_pkg::VS_W'(gblur_pkg::binom5(
			gblur_pkg::HS_W'(col[0].green), gblur_pkg::HS_W'(col[1].green),
			gblur_pkg::HS_W'(col[2].green), gblur_pkg::HS_W'(col[3].green),
			gblur_pkg::HS_W'(col[4].green)));
		vs_new.blue  = gblur_pkg::VS_W'(gblur_pkg::binom5(
			gblur_pkg::HS_W'(col[0].blue), gblur_pkg::HS_W'(col[1].blue),
			gblur_pkg::HS_W'(col[2].blue), gblur_pkg::HS_W'(col[3].blue),
			gblur_pkg::HS_W'(col[4].blue)));
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			for (int j = 0; j < gblur_pkg::KERNEL_SIZE - 1; j++) begin
				hwin_q[j] <= hwin_q[j + 1];
			end
			hwin_q[gblur_pkg::KERNEL_SIZE - 1] <= vs_new;
		end
	end

	// horizontal weighting, top byte is the divide by 256
	always_comb begin
		hs_red   = gblur_pkg::binom5(
			gblur_pkg::HS_W'(hwin_q[0].red), gblur_pkg::HS_W'(hwin_q[1].red),
			gblur_pkg::HS_W'(hwin_q[2].red), gblur_pkg::HS_W'(hwin_q[3].red),
			gblur_pkg::HS_W'(hwin_q[4].red));
		hs_green = gblur_pkg::binom5(
			gblur_pkg::HS_W'(hwin_q[0].green), gblur_pkg::HS_W'(hwin_q[1].green),
			gblur_pkg::HS_W'(hwin_q[2].green), gblur_pkg::HS_W'(hwin_q[3].green),
			gblur_pkg::HS_W'(hwin_q[4].green));
		hs_blue  = gblur_pkg::binom5(
			gblur_pkg::HS_W'(hwin_q[0].blue), gblur_pkg::HS_W'(hwin_q[1].blue),
			gblur_pkg::HS_W'(hwin_q[2].blue), gblur_pkg::HS_W'(hwin_q[3].blue),
			gblur_pkg::HS_W'(hwin_q[4].blue));
		blur.red   = hs_red[gblur_pkg::HS_W-1 -: gblur_pkg::CH_W];
		blur.green = hs_green[gblur_pkg::HS_W-1 -: gblur_pkg::CH_W];
		blur.blue  = hs_blue[gblur_pkg::HS_W-1 -: gblur_pkg::CH_W];
	end

endmodule
